[rtl/srrs_pkg.sv]
// Package for the sensor read retry sequencer: phase codes, word types, register map.
package srrs_pkg;

	typedef enum logic [3:0] {
		PH_IDLE           = 4'd0,
		PH_INIT           = 4'd1,
		PH_SETUP_CHECK    = 4'd2,
		PH_PREPARE        = 4'd3,
		PH_PREPARED_CHECK = 4'd4,
		PH_GET            = 4'd5,
		PH_GET_CHECK      = 4'd6,
		PH_READY          = 4'd7,
		PH_END            = 4'd8,
		PH_WAIT           = 4'd9
	} phase_t;

	localparam int unsigned ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_ERROR_COUNT_LIMIT = 2'd0,
		REG_RETRY_LIMIT       = 2'd1,
		REG_RETRY_DELAY_MS    = 2'd2,
		REG_TEST_MODE         = 2'd3
	} reg_idx_t;

	localparam logic [7:0]  ERROR_COUNT_LIMIT_RST = 8'd5;
	localparam logic [7:0]  RETRY_LIMIT_RST       = 8'd3;
	localparam logic [15:0] RETRY_DELAY_MS_RST    = 16'd100;

	typedef struct packed {
		logic        start_request;
		logic        clear_ready;
		logic [7:0]  error_count;
		logic        sensor_configured;
		logic        setup_succeeded;
		logic [15:0] sensor_delay_ms;
		logic [31:0] sensor_start_ms;
		logic [31:0] now_ms;
		logic        prepared;
		logic        transfer_end;
		logic        already_read;
		logic        read_success;
	} step_t;

	typedef struct packed {
		logic       cmd_reset_prepared;
		logic       cmd_clear_configured;
		logic       cmd_setup;
		logic       cmd_prepare;
		logic       cmd_get;
		logic       cmd_test_flag;
		logic       busy_res;
		logic       data_ready;
		logic [3:0] phase;
	} result_t;

endpackage

[rtl/srrs_step_if.sv]
// Valid/ready channel interface carrying one scheduler step word.
interface srrs_step_if
	import srrs_pkg::*;
();
	logic  valid;
	logic  ready;
	step_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/srrs_result_if.sv]
// Valid/ready channel interface carrying one result word.
interface srrs_result_if
	import srrs_pkg::*;
();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/sensor_read_retry_sequencer_core.sv]
// Sensor read retry sequencer: input register, one step of sequencing logic, result register.
// The step word is held in the input register and its result word in the result register.
// Throughput: one step word per clock when result_out.ready does not stall; the sequence
// state updates as each word moves into the result register, so back-to-back words chain directly.
// Reset (arst_n low, async): phase idle, counters and timers zero, flags clear,
// configuration registers at their defaults (limit 5, retries 3, delay 100 ms, test off).
module sensor_read_retry_sequencer_core
	import srrs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	srrs_step_if.sink           step_in,
	srrs_result_if.source       result_out,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// configuration registers
	logic [7:0]  err_limit_q;
	logic [7:0]  retry_limit_q;
	logic [15:0] retry_delay_q;
	logic        test_mode_q;

	// sequence state
	phase_t      phase_q;
	phase_t      resume_q;
	logic [7:0]  attempt_q;
	logic [31:0] wait_start_q;
	logic [15:0] wait_len_q;
	logic        busy_q;
	logic        ready_q;

	// pipeline
	logic        valid_s1;
	step_t       step_s1;
	logic        valid_s2;
	result_t     res_s2;

	logic        advance;
	reg_idx_t    reg_sel;
	logic        cfg_wr;

	// next-state values
	phase_t      eff_phase;
	logic        eff_busy;
	logic        eff_ready;
	phase_t      phase_d;
	phase_t      resume_d;
	logic [7:0]  attempt_d;
	logic [7:0]  attempt_inc;
	logic [31:0] wait_start_d;
	logic [15:0] wait_len_d;
	logic        busy_d;
	logic        ready_d;
	logic        too_many_err;
	logic        cfg_kept;
	logic        wait_done;
	logic [31:0] elapsed;

	// command outputs
	logic        c_rst;
	logic        c_clr;
	logic        c_setup;
	logic        c_prep;
	logic        c_get;
	result_t     res_d;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_limit_q   <= ERROR_COUNT_LIMIT_RST;
			retry_limit_q <= RETRY_LIMIT_RST;
			retry_delay_q <= RETRY_DELAY_MS_RST;
			test_mode_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_ERROR_COUNT_LIMIT: err_limit_q   <= pwdata[7:0];
				REG_RETRY_LIMIT:       retry_limit_q <= pwdata[7:0];
				REG_RETRY_DELAY_MS:    retry_delay_q <= pwdata[15:0];
				REG_TEST_MODE: begin
					// test flag is frozen while a reading runs
					if (!busy_q)
						test_mode_q <= pwdata[0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ERROR_COUNT_LIMIT: prdata = {24'd0, err_limit_q};
			REG_RETRY_LIMIT:       prdata = {24'd0, retry_limit_q};
			REG_RETRY_DELAY_MS:    prdata = {16'd0, retry_delay_q};
			REG_TEST_MODE:         prdata = {31'd0, test_mode_q};
		endcase
	end

	// ---------------- handshake ----------------
	assign advance          = valid_s1 & (~valid_s2 | result_out.ready);
	assign step_in.ready    = ~valid_s1 | advance;
	assign result_out.valid = valid_s2;
	assign result_out.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (step_in.ready)
				valid_s1 <= step_in.valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (result_out.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_in.valid && step_in.ready)
			step_s1 <= step_in.data;
		if (advance)
			res_s2 <= res_d;
	end

	// ---------------- step logic: next state ----------------
	// clear and start are applied ahead of the phase step
	assign eff_phase    = (step_s1.start_request && !busy_q) ? PH_INIT : phase_q;
	assign eff_busy     = busy_q | step_s1.start_request;
	assign eff_ready    = step_s1.clear_ready ? 1'b0 : ready_q;
	assign attempt_inc  = attempt_q + 8'd1;
	assign too_many_err = step_s1.error_count > err_limit_q;
	assign cfg_kept     = step_s1.sensor_configured & ~too_many_err;
	assign elapsed      = step_s1.now_ms - wait_start_q;
	assign wait_done    = elapsed > {16'd0, wait_len_q};

	always_comb begin
		phase_d      = eff_phase;
		resume_d     = resume_q;
		attempt_d    = attempt_q;
		wait_start_d = wait_start_q;
		wait_len_d   = wait_len_q;
		busy_d       = eff_busy;
		ready_d      = eff_ready;
		unique case (eff_phase)
			PH_INIT: begin
				attempt_d = 8'd0;
				ready_d   = 1'b0;
				phase_d   = PH_SETUP_CHECK;
			end
			PH_SETUP_CHECK: begin
				if (cfg_kept || step_s1.setup_succeeded)
					phase_d = PH_PREPARE;
				else
					phase_d = PH_END;
			end
			PH_PREPARE, PH_GET: begin
				wait_len_d   = step_s1.sensor_delay_ms;
				wait_start_d = step_s1.sensor_start_ms;
				if (step_s1.sensor_delay_ms != 16'd0) begin
					resume_d = (eff_phase == PH_PREPARE) ? PH_PREPARED_CHECK : PH_GET_CHECK;
					phase_d  = PH_WAIT;
				end else begin
					phase_d  = (eff_phase == PH_PREPARE) ? PH_PREPARED_CHECK : PH_GET_CHECK;
				end
			end
			PH_PREPARED_CHECK, PH_GET_CHECK: begin
				if (eff_phase == PH_GET_CHECK
				    && !(step_s1.transfer_end && !step_s1.already_read)) begin
					phase_d = PH_GET;
				end else if ((eff_phase == PH_PREPARED_CHECK && step_s1.prepared)
				             || (eff_phase == PH_GET_CHECK && step_s1.read_success)) begin
					attempt_d = 8'd0;
					phase_d   = (eff_phase == PH_PREPARED_CHECK) ? PH_GET : PH_READY;
				end else if (attempt_inc < retry_limit_q) begin
					attempt_d    = attempt_inc;
					wait_len_d   = retry_delay_q;
					wait_start_d = step_s1.now_ms;
					resume_d     = (eff_phase == PH_PREPARED_CHECK) ? PH_PREPARE : PH_GET;
					phase_d      = PH_WAIT;
				end else begin
					attempt_d = 8'd0;
					phase_d   = PH_END;
				end
			end
			PH_READY: begin
				ready_d = 1'b1;
				phase_d = PH_END;
			end
			PH_END: begin
				busy_d  = 1'b0;
				phase_d = PH_IDLE;
			end
			PH_WAIT: begin
				if (wait_done)
					phase_d = resume_q;
			end
			default: phase_d = eff_phase;
		endcase
	end

	// ---------------- step logic: command outputs ----------------
	always_comb begin
		c_rst   = 1'b0;
		c_clr   = 1'b0;
		c_setup = 1'b0;
		c_prep  = 1'b0;
		c_get   = 1'b0;
		unique case (eff_phase)
			PH_INIT:        c_rst = 1'b1;
			PH_SETUP_CHECK: begin
				// clear and setup can go out together on an error overrun
				c_clr   = too_many_err;
				c_setup = ~cfg_kept;
			end
			PH_PREPARE:     c_prep = 1'b1;
			PH_GET:         c_get  = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		res_d.cmd_reset_prepared   = c_rst;
		res_d.cmd_clear_configured = c_clr;
		res_d.cmd_setup            = c_setup;
		res_d.cmd_prepare          = c_prep;
		res_d.cmd_get              = c_get;
		res_d.cmd_test_flag        = (c_rst | c_prep | c_get) & test_mode_q;
		res_d.busy_res             = busy_d;
		res_d.data_ready           = ready_d;
		res_d.phase                = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			resume_q     <= PH_IDLE;
			attempt_q    <= 8'd0;
			wait_start_q <= 32'd0;
			wait_len_q   <= 16'd0;
			busy_q       <= 1'b0;
			ready_q      <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_d;
			resume_q     <= resume_d;
			attempt_q    <= attempt_d;
			wait_start_q <= wait_start_d;
			wait_len_q   <= wait_len_d;
			busy_q       <= busy_d;
			ready_q      <= ready_d;
		end
	end

	// ---------------- assertions ----------------
	a_active_is_busy: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> busy_q)
		else $error("sequence active without busy flag");

	a_wait_resume: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WAIT |-> (resume_q == PH_PREPARE || resume_q == PH_PREPARED_CHECK
		                        || resume_q == PH_GET || resume_q == PH_GET_CHECK))
		else $error("wait resumes to a phase that issues no retry");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0({res_s2.cmd_reset_prepared, res_s2.cmd_setup,
		                       res_s2.cmd_prepare, res_s2.cmd_get}))
		else $error("more than one sensor command in a result word");

	a_test_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.cmd_test_flag |->
			(res_s2.cmd_reset_prepared || res_s2.cmd_prepare || res_s2.cmd_get))
		else $error("test flag without a command that carries it");

	a_word_moves: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("stepped word lost before result register");

endmodule
